// ===== hw/rtl/mrm_pkg.sv =====
`default_nettype none

package mrm_pkg;

    typedef enum logic [1:0] {
        CMD_VIDEO = 2'd0,
        CMD_AUDIO = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_CLEAR = 2'd3
    } mrm_cmd_t;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } mrm_alu_op_t;

    typedef struct packed {
        mrm_cmd_t    cmd;
        logic [23:0] frame_bytes;
    } mrm_in_t;

    typedef struct packed {
        logic [31:0] video_bitrate;
        logic [15:0] video_fps;
        logic [15:0] audio_fps;
        logic [31:0] audio_bitrate;
        logic [47:0] total_video_bytes;
        logic [31:0] total_video_frames;
        logic [47:0] total_audio_bytes;
        logic [31:0] total_audio_frames;
    } mrm_out_t;

    localparam int CFG_W = 7;

endpackage

`default_nettype wire

// ===== hw/rtl/mrm_alu.sv =====
`default_nettype none

module mrm_alu #(
    parameter int W = 39
) (
    input  wire  [W-1:0]         a,
    input  wire  [W-1:0]         b,
    input  mrm_pkg::mrm_alu_op_t op,
    output logic [W-1:0]         y,
    output logic                 carry
);
    import mrm_pkg::*;

    logic [W:0] sum;

    // subtract as a + ~b + 1, carry out high means a >= b
    always_comb
    begin
        unique case (op)
            ALU_ADD: sum = {1'b0, a} + {1'b0, b};
            ALU_SUB: sum = {1'b0, a} + {1'b0, ~b} + {{W{1'b0}}, 1'b1};
            default: sum = '0;
        endcase
        y     = sum[W-1:0];
        carry = sum[W];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/media_rate_meter_unit.sv =====
// channel | direction | handshake          | beat
// --------+-----------+--------------------+-------------------------------
// in      | input     | in_valid / in_stall | mrm_in_t: cmd, frame_bytes
// out     | output    | out_valid/out_stall | mrm_out_t: rates and totals
// cfg     | input     | cfg_wr_en           | cfg_wr_data: window_len
//
// frame and clear beats pass through S_DONE only; a tick runs S_SUB, S_ADD, S_DIV and S_DONE,
// with S_DIV set by the restoring divider running on the shared adder
// the adder also does the ring subtract and add, one per cycle; slot data sits in a ram
// reset zeroes all counters and clears the slot valid flops at once, no sweep
// in_stall is high while a beat is in work; a pending output beat does not block input,
// only the final load of the output register waits for out_stall to drop

`default_nettype none

module media_rate_meter_unit #(
    parameter int WINDOW_MAX = 64
) (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       in_valid,
    output logic                      in_stall,
    input  mrm_pkg::mrm_in_t          in_data,
    output logic                      out_valid,
    input  wire                       out_stall,
    output mrm_pkg::mrm_out_t         out_data,
    input  wire                       cfg_wr_en,
    input  wire [mrm_pkg::CFG_W-1:0]  cfg_wr_data
);
    import mrm_pkg::*;

    localparam int LW  = $clog2(WINDOW_MAX + 1);
    localparam int PW  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int TW  = 32 + LW;
    localparam int CW  = (LW > CFG_W) ? LW : CFG_W;
    localparam int NW  = $clog2(TW);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SUB,
        S_ADD,
        S_DIV,
        S_DONE
    } state_t;

    state_t            state_reg;
    logic [CFG_W-1:0]  window_len_reg;
    logic [31:0]       sec_vbytes_reg;
    logic [31:0]       sec_abytes_reg;
    logic [15:0]       sec_vframes_reg;
    logic [15:0]       sec_aframes_reg;
    logic [WINDOW_MAX-1:0] slot_valid_reg;
    logic [TW-1:0]     window_total_reg;
    logic [PW-1:0]     slot_pos_reg;
    logic [LW-1:0]     ticks_reg;
    logic [31:0]       rep_vbitrate_reg;
    logic [15:0]       rep_vfps_reg;
    logic [15:0]       rep_afps_reg;
    logic [31:0]       rep_abitrate_reg;
    logic [47:0]       tot_vbytes_reg;
    logic [31:0]       tot_vframes_reg;
    logic [47:0]       tot_abytes_reg;
    logic [31:0]       tot_aframes_reg;
    logic [TW-1:0]     rem_reg;
    logic [TW-1:0]     quo_reg;
    logic [NW-1:0]     step_reg;
    logic              out_valid_reg;
    mrm_out_t          out_data_reg;

    logic [31:0]       slot_mem [WINDOW_MAX];
    logic [31:0]       slot_rd_reg;

    logic [CW-1:0]     wl_ext;
    logic [LW-1:0]     eff_len;
    logic [PW-1:0]     pos_sel;
    logic [LW-1:0]     pos_inc;
    logic [PW-1:0]     pos_next;
    logic [LW-1:0]     ticks_next;
    logic [32:0]       vsum;
    logic [32:0]       asum;
    logic [TW-1:0]     div_cand;
    logic [TW-1:0]     alu_a;
    logic [TW-1:0]     alu_b;
    mrm_alu_op_t       alu_op;
    logic [TW-1:0]     alu_y;
    logic              alu_carry;
    logic              in_fire;
    logic              out_free;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_fire   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // window length clamped to [1, WINDOW_MAX]
    always_comb
    begin
        wl_ext = CW'(window_len_reg);
        if (wl_ext == '0)
            eff_len = LW'(1);
        else if (wl_ext > CW'(WINDOW_MAX))
            eff_len = LW'(WINDOW_MAX);
        else
            eff_len = LW'(wl_ext);
    end

    always_comb
    begin
        pos_sel    = (LW'(slot_pos_reg) >= eff_len) ? '0 : slot_pos_reg;
        pos_inc    = LW'(pos_sel) + LW'(1);
        pos_next   = (pos_inc >= eff_len) ? '0 : PW'(pos_inc);
        ticks_next = (ticks_reg < eff_len) ? ticks_reg + LW'(1) : eff_len;
        vsum       = {1'b0, sec_vbytes_reg} + {9'b0, in_data.frame_bytes};
        asum       = {1'b0, sec_abytes_reg} + {9'b0, in_data.frame_bytes};
        div_cand   = {rem_reg[TW-2:0], quo_reg[TW-1]};
    end

    always_comb
    begin
        alu_a  = '0;
        alu_b  = '0;
        alu_op = ALU_ADD;
        unique case (state_reg)
            S_SUB:
            begin
                alu_a  = window_total_reg;
                alu_b  = slot_valid_reg[pos_sel] ? TW'(slot_rd_reg) : '0;
                alu_op = ALU_SUB;
            end
            S_ADD:
            begin
                alu_a  = window_total_reg;
                alu_b  = TW'(sec_vbytes_reg);
                alu_op = ALU_ADD;
            end
            S_DIV:
            begin
                alu_a  = div_cand;
                alu_b  = TW'(ticks_reg);
                alu_op = ALU_SUB;
            end
            default:
            begin
                alu_a  = '0;
                alu_b  = '0;
                alu_op = ALU_ADD;
            end
        endcase
    end

    mrm_alu #(
        .W (TW)
    ) u_alu (
        .a     (alu_a),
        .b     (alu_b),
        .op    (alu_op),
        .y     (alu_y),
        .carry (alu_carry)
    );

    always_ff @(posedge clk)
    begin
        if (in_fire && in_data.cmd == CMD_TICK)
            slot_rd_reg <= slot_mem[pos_sel];
        if (state_reg == S_ADD)
            slot_mem[pos_sel] <= sec_vbytes_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            window_len_reg   <= CFG_W'(8);
            sec_vbytes_reg   <= '0;
            sec_abytes_reg   <= '0;
            sec_vframes_reg  <= '0;
            sec_aframes_reg  <= '0;
            slot_valid_reg   <= '0;
            window_total_reg <= '0;
            slot_pos_reg     <= '0;
            ticks_reg        <= '0;
            rep_vbitrate_reg <= '0;
            rep_vfps_reg     <= '0;
            rep_afps_reg     <= '0;
            rep_abitrate_reg <= '0;
            tot_vbytes_reg   <= '0;
            tot_vframes_reg  <= '0;
            tot_abytes_reg   <= '0;
            tot_aframes_reg  <= '0;
            rem_reg          <= '0;
            quo_reg          <= '0;
            step_reg         <= '0;
            out_valid_reg    <= 1'b0;
            out_data_reg     <= '0;
        end
        else
        begin
            // in S_DONE the load below decides the output valid
            if (out_valid_reg && !out_stall && state_reg != S_DONE)
                out_valid_reg <= 1'b0;

            // a new window length restarts the ring
            if (cfg_wr_en)
            begin
                window_len_reg   <= cfg_wr_data;
                slot_valid_reg   <= '0;
                window_total_reg <= '0;
                slot_pos_reg     <= '0;
                ticks_reg        <= '0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        unique case (in_data.cmd)
                            CMD_VIDEO:
                            begin
                                tot_vbytes_reg  <= tot_vbytes_reg + {24'b0, in_data.frame_bytes};
                                tot_vframes_reg <= tot_vframes_reg + 32'd1;
                                sec_vbytes_reg  <= vsum[32] ? 32'hFFFF_FFFF : vsum[31:0];
                                if (sec_vframes_reg != 16'hFFFF)
                                    sec_vframes_reg <= sec_vframes_reg + 16'd1;
                                state_reg <= S_DONE;
                            end
                            CMD_AUDIO:
                            begin
                                tot_abytes_reg  <= tot_abytes_reg + {24'b0, in_data.frame_bytes};
                                tot_aframes_reg <= tot_aframes_reg + 32'd1;
                                sec_abytes_reg  <= asum[32] ? 32'hFFFF_FFFF : asum[31:0];
                                if (sec_aframes_reg != 16'hFFFF)
                                    sec_aframes_reg <= sec_aframes_reg + 16'd1;
                                state_reg <= S_DONE;
                            end
                            CMD_TICK:
                            begin
                                state_reg <= S_SUB;
                            end
                            CMD_CLEAR:
                            begin
                                rep_vbitrate_reg <= '0;
                                rep_vfps_reg     <= '0;
                                rep_afps_reg     <= '0;
                                rep_abitrate_reg <= '0;
                                tot_vbytes_reg   <= '0;
                                tot_vframes_reg  <= '0;
                                tot_abytes_reg   <= '0;
                                tot_aframes_reg  <= '0;
                                sec_vbytes_reg   <= '0;
                                sec_abytes_reg   <= '0;
                                sec_vframes_reg  <= '0;
                                sec_aframes_reg  <= '0;
                                slot_valid_reg   <= '0;
                                window_total_reg <= '0;
                                state_reg        <= S_DONE;
                            end
                            default:
                            begin
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end
                S_SUB:
                begin
                    // retire the old slot from the running sum
                    window_total_reg <= alu_y;
                    state_reg        <= S_ADD;
                end
                S_ADD:
                begin
                    window_total_reg        <= alu_y;
                    slot_valid_reg[pos_sel] <= 1'b1;
                    slot_pos_reg            <= pos_next;
                    ticks_reg               <= ticks_next;
                    quo_reg                 <= alu_y;
                    rem_reg                 <= '0;
                    step_reg                <= '0;
                    state_reg               <= S_DIV;
                end
                S_DIV:
                begin
                    rem_reg  <= alu_carry ? alu_y : div_cand;
                    quo_reg  <= {quo_reg[TW-2:0], alu_carry};
                    step_reg <= step_reg + NW'(1);
                    if (step_reg == NW'(TW - 1))
                    begin
                        rep_vbitrate_reg <= {quo_reg[30:0], alu_carry};
                        rep_vfps_reg     <= sec_vframes_reg;
                        rep_afps_reg     <= sec_aframes_reg;
                        rep_abitrate_reg <= sec_abytes_reg;
                        sec_vbytes_reg   <= '0;
                        sec_abytes_reg   <= '0;
                        sec_vframes_reg  <= '0;
                        sec_aframes_reg  <= '0;
                        state_reg        <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg                   <= 1'b1;
                        out_data_reg.video_bitrate      <= rep_vbitrate_reg;
                        out_data_reg.video_fps          <= rep_vfps_reg;
                        out_data_reg.audio_fps          <= rep_afps_reg;
                        out_data_reg.audio_bitrate      <= rep_abitrate_reg;
                        out_data_reg.total_video_bytes  <= tot_vbytes_reg;
                        out_data_reg.total_video_frames <= tot_vframes_reg;
                        out_data_reg.total_audio_bytes  <= tot_abytes_reg;
                        out_data_reg.total_audio_frames <= tot_aframes_reg;
                        state_reg                       <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/mrm_checker.sv =====
`default_nettype none

module mrm_checker (
    input wire                clk,
    input wire                rst_n,
    input wire                in_valid,
    input wire                in_stall,
    input mrm_pkg::mrm_in_t   in_data,
    input wire                out_valid,
    input wire                out_stall,
    input mrm_pkg::mrm_out_t  out_data
);
    import mrm_pkg::*;

    // a stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("output beat changed while stalled");

    // one beat in work at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken while a beat is in work");

    // a clear with the output empty shows zeroed stats once S_DONE has loaded the output register
    a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && in_data.cmd == CMD_CLEAR && !out_valid |=> ##1
        (out_valid && out_data.video_bitrate == '0 && out_data.video_fps == '0 &&
         out_data.audio_fps == '0 && out_data.audio_bitrate == '0 &&
         out_data.total_video_bytes == '0 && out_data.total_video_frames == '0 &&
         out_data.total_audio_bytes == '0 && out_data.total_audio_frames == '0))
        else $error("clear did not zero the reported stats");

endmodule

bind media_rate_meter_unit mrm_checker u_mrm_checker (.*);

`default_nettype wire
